FILE: design/fedl_pkg.sv
// ============================================================================
// fedl_pkg
// Shared widths, register codes and the result word type of the feedback
// echo delay line.
// ============================================================================
package fedl_pkg;

    localparam int DEF_MAX_DELAY_DEPTH = 65536;
    localparam int DEF_GAIN_FRAC_BITS  = 14;

    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;
    localparam int APB_W    = 32;
    localparam int ADDR_W   = 3;

    // Unsigned 16-bit gain made signed (17 bits) times a 16-bit sample.
    localparam int PROD_W = 33;
    // Sum of the sample scaled by up to 2^16 and the product, with a guard bit.
    localparam int ACC_W  = 34;

    localparam int OUT_FIFO_DEPTH = 4;

    // Register select, taken from paddr bit 2 (word index).
    localparam logic REG_DELAY = 1'b0;
    localparam logic REG_GAIN  = 1'b1;

    typedef struct packed {
        logic                       last;
        logic                       ovf;
        logic signed [SAMPLE_W-1:0] sample;
    } out_word_t;

endpackage

FILE: design/feedback_echo_delay_line.sv
// ============================================================================
// feedback_echo_delay_line
// Feedback comb filter: y = trunc(x + gain * y[n - delay]) on a stream of
// signed 16-bit samples, with the delay line held in one synchronous memory.
// ============================================================================
// The block takes one sample word per clock while the output queue has room
// and returns one result word per sample. The delay line is a single memory
// with one read and one write port; the read issued at acceptance and the
// write of the result from stage 2 lie close enough together that only a
// delay of exactly one sample needs an interlock: then no new word is taken
// while the last one is in stage 1. Entries not yet written since reset read
// as zero through a fill marker, so no clearing pass runs after reset. A sum
// outside the 16-bit range passes the input sample unchanged and sets the
// tuser flag. Registers are to be written over the APB port only while the
// stream is idle; the block does not enforce it. delay_samples is at address
// 0 and level_gain (unsigned, GAIN_FRAC_BITS fraction bits) at address 4.
module feedback_echo_delay_line #(
    parameter int MAX_DELAY_DEPTH = fedl_pkg::DEF_MAX_DELAY_DEPTH,
    parameter int GAIN_FRAC_BITS  = fedl_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [fedl_pkg::SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample_in
    input  logic                          s_axis_tlast,   // last_in

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [fedl_pkg::SAMPLE_W-1:0] m_axis_tdata,   // [15:0] sample_out
    output logic                          m_axis_tuser,   // [0] overflow_kept
    output logic                          m_axis_tlast,   // last_out

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fedl_pkg::ADDR_W-1:0]   paddr,
    input  logic [fedl_pkg::APB_W-1:0]    pwdata,
    output logic [fedl_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);

    localparam int SW     = fedl_pkg::SAMPLE_W;
    localparam int CW     = fedl_pkg::CFG_W;
    localparam int ACC_W  = fedl_pkg::ACC_W;
    localparam int PROD_W = fedl_pkg::PROD_W;
    localparam int PTR_W  = $clog2(MAX_DELAY_DEPTH);
    localparam int CMP_W  = (PTR_W > CW) ? PTR_W : CW;
    localparam int FD     = fedl_pkg::OUT_FIFO_DEPTH;
    localparam int FIX_W  = $clog2(FD);
    localparam int CNT_W  = $clog2(FD + 1);

    localparam logic [CMP_W-1:0] DLY_MAX  = CMP_W'(MAX_DELAY_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_V  = (PTR_W + 1)'(MAX_DELAY_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_DELAY_DEPTH - 1);

    localparam logic [ACC_W-1:0]        FRAC_MASK = (ACC_W'(1) << GAIN_FRAC_BITS) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Y_MAX     = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Y_MIN_M1  = -ACC_W'(32769);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0] delay_samples_reg;
    logic [CW-1:0] level_gain_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_samples_reg <= '0;
            level_gain_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                fedl_pkg::REG_DELAY: delay_samples_reg <= pwdata[CW-1:0];
                fedl_pkg::REG_GAIN:  level_gain_reg    <= pwdata[CW-1:0];
                default:             delay_samples_reg <= delay_samples_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            fedl_pkg::REG_DELAY: prdata = (fedl_pkg::APB_W)'(delay_samples_reg);
            fedl_pkg::REG_GAIN:  prdata = (fedl_pkg::APB_W)'(level_gain_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Accept stage: write pointer, read address, fill marker
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] dly_wide;
    logic [PTR_W-1:0] dly_eff;
    logic             dly_zero;
    logic             dly_one;
    logic             wp_ge;
    logic [PTR_W-1:0] rd_addr;
    logic             in_accept;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic             wrapped_reg, wrapped_next;

    assign dly_wide = CMP_W'(delay_samples_reg);
    assign dly_eff  = (dly_wide > DLY_MAX) ? PTR_W'(DLY_MAX) : PTR_W'(dly_wide);
    assign dly_zero = (dly_eff == '0);
    assign dly_one  = (dly_eff == PTR_W'(1));
    assign wp_ge    = (wp_reg >= dly_eff);
    assign rd_addr  = wp_ge ? (wp_reg - dly_eff)
                            : PTR_W'({1'b0, wp_reg} + DEPTH_V - {1'b0, dly_eff});

    always_comb
    begin
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        if (in_accept)
        begin
            if (wp_reg == PTR_LAST)
            begin
                wp_next      = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                wp_next = wp_reg + PTR_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic                     s1_valid_reg;
    logic signed [SW-1:0]     s1_x_reg;
    logic                     s1_last_reg;
    logic [PTR_W-1:0]         s1_rp_reg;
    logic [PTR_W-1:0]         s1_wp_reg;
    logic                     s1_zero_reg;
    logic                     s1_filled_reg;

    logic                     s2_valid_reg;
    logic signed [SW-1:0]     s2_x_reg;
    logic                     s2_last_reg;
    logic [PTR_W-1:0]         s2_wp_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;

    logic                     fwd_valid_reg;
    logic [PTR_W-1:0]         fwd_addr_reg;
    logic signed [SW-1:0]     fwd_data_reg;

    logic [SW-1:0]            rd_data_reg;
    logic [SW-1:0]            delay_mem [MAX_DELAY_DEPTH];

    logic signed [SW-1:0]     d_s1;
    logic signed [PROD_W-1:0] prod_s1;
    logic signed [SW-1:0]     emit_s2;
    logic                     ovf_s2;

    // Delay memory: one read at acceptance, one write of the finished result.
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            delay_mem[s2_wp_reg] <= emit_s2;
        end
        rd_data_reg <= delay_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            s1_valid_reg  <= in_accept;
            s2_valid_reg  <= s1_valid_reg;
            fwd_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg      <= $signed(s_axis_tdata);
        s1_last_reg   <= s_axis_tlast;
        s1_rp_reg     <= rd_addr;
        s1_wp_reg     <= wp_reg;
        s1_zero_reg   <= dly_zero;
        s1_filled_reg <= wrapped_reg || wp_ge;

        s2_x_reg      <= s1_x_reg;
        s2_last_reg   <= s1_last_reg;
        s2_wp_reg     <= s1_wp_reg;
        s2_prod_reg   <= prod_s1;

        fwd_addr_reg  <= s2_wp_reg;
        fwd_data_reg  <= emit_s2;
    end

    // ------------------------------------------------------------------
    // Stage 1: pick the delayed sample and multiply by the gain
    // ------------------------------------------------------------------
    // The memory read misses a write made at the same edge; that write is
    // caught by the forwarding register. A write at the following edge can only
    // hit with a delay of one, which the input interlock keeps apart.
    always_comb
    begin
        if (s1_zero_reg)
        begin
            d_s1 = s1_x_reg;
        end
        else if (!s1_filled_reg)
        begin
            d_s1 = '0;
        end
        else if (fwd_valid_reg && (fwd_addr_reg == s1_rp_reg))
        begin
            d_s1 = fwd_data_reg;
        end
        else
        begin
            d_s1 = $signed(rd_data_reg);
        end
    end

    assign prod_s1 = $signed({1'b0, level_gain_reg}) * d_s1;

    // ------------------------------------------------------------------
    // Stage 2: add, truncate toward zero, range check
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_s2;
    logic signed [ACC_W-1:0] floor_s2;
    logic                    corr_s2;
    logic                    ovf_hi;
    logic                    ovf_lo;

    assign acc_s2   = (ACC_W'(s2_x_reg) <<< GAIN_FRAC_BITS) + ACC_W'(s2_prod_reg);
    assign floor_s2 = acc_s2 >>> GAIN_FRAC_BITS;
    // A negative sum with a nonzero fraction rounds up by one toward zero.
    assign corr_s2  = acc_s2[ACC_W-1] && ((acc_s2 & FRAC_MASK) != '0);
    assign ovf_hi   = (floor_s2 > Y_MAX);
    assign ovf_lo   = (floor_s2 < Y_MIN_M1) || ((floor_s2 == Y_MIN_M1) && !corr_s2);
    assign ovf_s2   = ovf_hi || ovf_lo;
    assign emit_s2  = ovf_s2 ? s2_x_reg : $signed(floor_s2[SW-1:0] + SW'(corr_s2));

    // ------------------------------------------------------------------
    // Output queue: the pipeline never stalls, so input ready reserves
    // a slot for every word still in flight.
    // ------------------------------------------------------------------
    fedl_pkg::out_word_t fifo_mem [FD];
    logic [FIX_W-1:0]    head_reg, head_next;
    logic [FIX_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W:0]      occ;
    logic                out_pop;
    logic                out_push;
    fedl_pkg::out_word_t push_word;
    fedl_pkg::out_word_t head_word;

    assign out_push  = s2_valid_reg;
    assign out_pop   = m_axis_tvalid && m_axis_tready;
    assign occ       = (CNT_W + 1)'(count_reg) + (CNT_W + 1)'(s1_valid_reg)
                     + (CNT_W + 1)'(s2_valid_reg);
    assign s_axis_tready = (occ < (CNT_W + 1)'(FD)) && !(dly_one && s1_valid_reg);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign push_word.last   = s2_last_reg;
    assign push_word.ovf    = ovf_s2;
    assign push_word.sample = emit_s2;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (out_pop)
        begin
            head_next = (head_reg == FIX_W'(FD - 1)) ? '0 : head_reg + FIX_W'(1);
        end
        if (out_push)
        begin
            tail_next = (tail_reg == FIX_W'(FD - 1)) ? '0 : tail_reg + FIX_W'(1);
        end
        if (out_push && !out_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (out_pop && !out_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            fifo_mem[tail_reg] <= push_word;
        end
    end

    assign head_word     = fifo_mem[head_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = head_word.sample;
    assign m_axis_tuser  = head_word.ovf;
    assign m_axis_tlast  = head_word.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_queue_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        occ <= (CNT_W + 1)'(FD))
        else $error("output queue overrun: more words in flight than slots");

    a_delay_one_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        dly_one |-> !(s1_valid_reg && s2_valid_reg))
        else $error("back-to-back words in flight with a delay of one");

    a_wp_moves_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(wp_reg))
        else $error("write pointer moved without an accepted word");

    a_ovf_keeps_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && ovf_s2) |-> (emit_s2 == s2_x_reg))
        else $error("overflow result does not keep the input sample");

    a_push_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> ##1 out_push)
        else $error("accepted word did not reach the output queue");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the feedback echo delay line. A scoreboard model of
// the comb filter (delay memory, write pointer, delay and gain registers)
// predicts every output word. Directed words cover the field extremes,
// truncation, overflow and the delay corner cases. Random phases follow,
// one of them at the maximum delay. The sender is bursty and the receiver
// stalls, including long hold-offs.
// ============================================================================
module tb_top;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int LONG_HOLD       = 300;
    localparam int RANDOM_PHASES   = 12;
    localparam int MAX_DELAY_PHASE = 5;

    localparam logic [fedl_pkg::ADDR_W-1:0] ADDR_DELAY = {fedl_pkg::REG_DELAY, 2'b00};
    localparam logic [fedl_pkg::ADDR_W-1:0] ADDR_GAIN  = {fedl_pkg::REG_GAIN, 2'b00};

    typedef struct packed {
        logic                                 last;
        logic signed [fedl_pkg::SAMPLE_W-1:0] sample;
    } stream_item_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_THROTTLE} rx_mode_t;

    logic                            clk;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [fedl_pkg::SAMPLE_W-1:0]   s_axis_tdata  = '0;
    logic                            s_axis_tlast  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [fedl_pkg::SAMPLE_W-1:0]   m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [fedl_pkg::ADDR_W-1:0]     paddr         = '0;
    logic [fedl_pkg::APB_W-1:0]      pwdata        = '0;
    logic [fedl_pkg::APB_W-1:0]      prdata;
    logic                            pready;

    // Scoreboard copy of the filter state.
    logic signed [fedl_pkg::SAMPLE_W-1:0] echo_mem [0:65535];
    logic [15:0]                          echo_wp;
    logic [fedl_pkg::CFG_W-1:0]           cfg_delay;
    logic [fedl_pkg::CFG_W-1:0]           cfg_gain;

    stream_item_t          sample_feed_q[$];
    fedl_pkg::out_word_t   echo_expect_q[$];

    int       fail_count   = 0;
    int       results_seen = 0;
    int       idle_cycles  = 0;
    int       burst_left   = 1;
    int       gap_left     = 0;
    logic     drv_valid;
    int       hold_left    = 0;
    int       next_hold_at = 150;
    int       mode_left    = 0;
    rx_mode_t rx_mode      = RX_OPEN;

    feedback_echo_delay_line u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // One step of the comb filter for an accepted input word.
    function automatic void predict_echo(input logic signed [fedl_pkg::SAMPLE_W-1:0] x,
                                         input logic last);
        logic signed [fedl_pkg::SAMPLE_W-1:0] delayed;
        logic [15:0]                          rd_ptr;
        longint                               acc;
        longint                               sum;
        fedl_pkg::out_word_t                  word;
        rd_ptr = echo_wp - cfg_delay;
        delayed = (cfg_delay == 0) ? x : echo_mem[rd_ptr];
        acc = longint'(x) * (longint'(1) << fedl_pkg::DEF_GAIN_FRAC_BITS)
            + longint'(cfg_gain) * longint'(delayed);
        // Signed division truncates toward zero.
        sum = acc / (longint'(1) << fedl_pkg::DEF_GAIN_FRAC_BITS);
        word.last = last;
        if (sum > 32767 || sum < -32768)
        begin
            word.sample = x;
            word.ovf    = 1'b1;
        end
        else
        begin
            word.sample = sum[fedl_pkg::SAMPLE_W-1:0];
            word.ovf    = 1'b0;
        end
        echo_mem[echo_wp] = word.sample;
        echo_wp = echo_wp + 16'd1;
        echo_expect_q.push_back(word);
    endfunction

    function automatic logic [fedl_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sd32767;
            1:       return -16'sd32768;
            2:       return fedl_pkg::SAMPLE_W'($urandom_range(0, 2)) - 16'd1;
            3, 4:    return fedl_pkg::SAMPLE_W'($urandom_range(0, 2000)) - 16'd1000;
            default: return fedl_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [fedl_pkg::CFG_W-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd1;
            2, 3, 4: return fedl_pkg::CFG_W'($urandom_range(2, 8));
            5, 6, 7: return fedl_pkg::CFG_W'($urandom_range(9, 200));
            8:       return fedl_pkg::CFG_W'($urandom_range(201, 65535));
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [fedl_pkg::CFG_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd16384;
            3, 4, 5: return fedl_pkg::CFG_W'($urandom_range(0, 20000));
            default: return fedl_pkg::CFG_W'($urandom);
        endcase
    endfunction

    task automatic push_item(input logic signed [fedl_pkg::SAMPLE_W-1:0] sample,
                             input logic last);
        sample_feed_q.push_back('{last: last, sample: sample});
    endtask

    task automatic wait_idle();
        while (sample_feed_q.size() != 0 || echo_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [fedl_pkg::ADDR_W-1:0] addr,
                              input logic [fedl_pkg::CFG_W-1:0] value,
                              output logic [fedl_pkg::APB_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input logic [fedl_pkg::ADDR_W-1:0] addr,
                             input logic [fedl_pkg::CFG_W-1:0] value);
        logic [fedl_pkg::APB_W-1:0] rdata;
        apb_access(1'b0, addr, '0, rdata);
        if (rdata[fedl_pkg::CFG_W-1:0] !== value)
        begin
            $error("prdata at %0d: expected %0d, got %0d", addr, value,
                   rdata[fedl_pkg::CFG_W-1:0]);
            fail_count++;
        end
    endtask

    // Registers change only with the stream drained.
    task automatic configure(input logic [fedl_pkg::CFG_W-1:0] delay,
                             input logic [fedl_pkg::CFG_W-1:0] gain);
        logic [fedl_pkg::APB_W-1:0] unused;
        wait_idle();
        apb_access(1'b1, ADDR_DELAY, delay, unused);
        cfg_delay = delay;
        apb_access(1'b1, ADDR_GAIN, gain, unused);
        cfg_gain = gain;
        check_reg(ADDR_DELAY, delay);
        check_reg(ADDR_GAIN, gain);
    endtask

    // Sender: bursts of words with random gaps, sometimes none at all.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            drv_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_echo(s_axis_tdata, s_axis_tlast);
                void'(sample_feed_q.pop_front());
                drv_valid = 1'b0;
            end
            if (!drv_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (sample_feed_q.size() > 0)
                begin
                    drv_valid = 1'b1;
                    s_axis_tdata <= sample_feed_q[0].sample;
                    s_axis_tlast <= sample_feed_q[0].last;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_axis_tvalid <= drv_valid;
        end
    end

    // Receiver: checks each output word and stalls in changing patterns.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (echo_expect_q.size() == 0)
                begin
                    $error("unexpected output word: sample_out %0d", $signed(m_axis_tdata));
                    fail_count++;
                end
                else
                begin
                    fedl_pkg::out_word_t exp_word;
                    exp_word = echo_expect_q.pop_front();
                    if (m_axis_tdata !== exp_word.sample)
                    begin
                        $error("sample_out: expected %0d, got %0d",
                               exp_word.sample, $signed(m_axis_tdata));
                        fail_count++;
                    end
                    if (m_axis_tuser !== exp_word.ovf)
                    begin
                        $error("overflow_kept: expected %0b, got %0b", exp_word.ovf, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tlast !== exp_word.last)
                    begin
                        $error("last_out: expected %0b, got %0b", exp_word.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end

            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (results_seen >= next_hold_at && s_axis_tvalid
                     && sample_feed_q.size() > 8)
            begin
                // Long hold-off while words keep coming, so the block backs up.
                hold_left    = LONG_HOLD;
                next_hold_at = next_hold_at + 20000;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 200);
                end
                else
                begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_OPEN:     m_axis_tready <= 1'b1;
                    RX_RANDOM:   m_axis_tready <= 1'($urandom_range(0, 1));
                    default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        int phase;
        int count;
        int k;
        for (k = 0; k < 65536; k++)
            echo_mem[k] = '0;
        echo_wp   = '0;
        cfg_delay = '0;
        cfg_gain  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero delay and zero gain pass every sample through.
        push_item(16'sd32767, 1'b0);
        push_item(-16'sd32768, 1'b0);
        push_item(16'sd0, 1'b0);
        push_item(-16'sd1, 1'b0);
        push_item(16'sd1, 1'b1);

        // Zero delay at full gain: overflow at the extremes, truncation near zero.
        configure(16'd0, 16'hFFFF);
        push_item(16'sd32767, 1'b0);
        push_item(-16'sd32768, 1'b0);
        push_item(16'sd1, 1'b0);
        push_item(-16'sd1, 1'b0);
        push_item(16'sd12345, 1'b1);

        // Delay of one at unity gain; the first word reads the entry left by the run before.
        configure(16'd1, 16'd16384);
        push_item(16'sd100, 1'b0);
        push_item(16'sd100, 1'b0);
        push_item(-16'sd50, 1'b0);
        push_item(16'sd20000, 1'b0);
        push_item(16'sd20000, 1'b0);
        push_item(16'sd0, 1'b1);

        // New delay with the memory kept from the run before.
        configure(16'd3, 16'd8192);
        push_item(-16'sd32768, 1'b0);
        push_item(16'sd32767, 1'b0);
        push_item(16'sd7, 1'b0);
        push_item(-16'sd7, 1'b0);
        push_item(16'sd0, 1'b1);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == MAX_DELAY_PHASE)
            begin
                // Maximum delay: every word reads an entry written long ago or never.
                configure(16'hFFFF, fedl_pkg::CFG_W'($urandom_range(1000, 30000)));
            end
            else
            begin
                configure(pick_delay(), pick_gain());
            end
            count = $urandom_range(40, 80);
            for (k = 0; k < count; k++)
                push_item(pick_sample(), (k == count - 1) || ($urandom_range(0, 31) == 0));
        end

        wait_idle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/fedl_pkg.sv
design/feedback_echo_delay_line.sv
test/tb_top.sv
